>>> src/exp_golomb_bit_writer_unit_assert.svh
// Assertion macros shared by the Exp-Golomb bit writer modules.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef EXP_GOLOMB_BIT_WRITER_UNIT_ASSERT_SVH
`define EXP_GOLOMB_BIT_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define EGBW_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define EGBW_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/egbw_pkg.sv
// Shared constants and types of the Exp-Golomb bit writer.
// Used by every module of the block; depends on nothing.
package egbw_pkg;

    localparam int VALUE_BITS = 32;
    localparam int BYTE_BITS  = 8;
    localparam int CODE_BITS  = 65;
    localparam int LEN_BITS   = 7;
    localparam int ACC_BITS   = 72;
    localparam int MAX_BYTES  = 9;
    localparam int NBYTE_BITS = 4;
    localparam int RANGE_BITS = 33;
    localparam int COUNT_BITS = 6;
    localparam int KIND_BITS  = 3;
    localparam int IN_TDATA_BITS = 104;

    localparam logic [KIND_BITS-1:0] KIND_FIXED = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_UVAR  = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_UE    = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_SE    = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_ALIGN = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_TRAIL = 3'd5;

    typedef enum logic [1:0] {
        OP_BITS,
        OP_ALIGN,
        OP_TRAIL
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic                err;
        logic [CODE_BITS-1:0] code;
        logic [LEN_BITS-1:0]  len;
    } enc_t;

    typedef struct packed {
        logic                  err;
        logic [NBYTE_BITS-1:0] nbytes;
        logic [ACC_BITS-1:0]   data;
    } load_t;

endpackage

>>> src/egbw_encode.sv
// Input register and code-word builder of the Exp-Golomb bit writer.
// Turns one request into a right-aligned code word and its length; uses egbw_pkg.
module egbw_encode
    import egbw_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [KIND_BITS-1:0]         in_kind,
    input  logic [VALUE_BITS-1:0]        in_value,
    input  logic signed [VALUE_BITS-1:0] in_signed_value,
    input  logic [COUNT_BITS-1:0]        in_bit_count,
    input  logic [RANGE_BITS-1:0]        in_range,
    output logic                         out_valid,
    input  logic                         out_ready,
    output enc_t                         out_enc
);

    logic                   v_reg;
    logic [KIND_BITS-1:0]   kind_reg;
    logic [VALUE_BITS-1:0]  value_reg;
    logic [VALUE_BITS-1:0]  svalue_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [RANGE_BITS-1:0]  range_reg;

    logic                   drop;
    logic                   advance;
    logic [RANGE_BITS-1:0]  value_w;
    logic                   too_wide;
    logic                   fixed_err;
    logic                   uvar_err;
    logic                   neg;
    logic [VALUE_BITS-1:0]  mag;
    logic [RANGE_BITS-1:0]  mapped;
    logic [RANGE_BITS-1:0]  ue_x1;
    logic [5:0]             ue_n1;
    logic [LEN_BITS-1:0]    ue_len;
    logic [LEN_BITS-1:0]    uvar_len;

    function automatic logic [5:0] bit_len(input logic [RANGE_BITS-1:0] x);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < RANGE_BITS; i++)
        begin
            if (x[i])
            begin
                n = 6'(i + 1);
            end
        end
        return n;
    endfunction

    always_comb
    begin
        drop     = !(kind_reg inside {[KIND_FIXED:KIND_TRAIL]});
        advance  = v_reg && (drop || out_ready);
        in_ready = !v_reg || advance;
        out_valid = v_reg && !drop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            v_reg <= 1'b1;
        end
        else if (advance)
        begin
            v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg   <= in_kind;
            value_reg  <= in_value;
            svalue_reg <= in_signed_value;
            count_reg  <= in_bit_count;
            range_reg  <= in_range;
        end
    end

    always_comb
    begin
        value_w   = {1'b0, value_reg};
        too_wide  = (value_w >> VALUE_BITS) != '0;
        fixed_err = (count_reg > COUNT_BITS'(VALUE_BITS)) || ((value_w >> count_reg) != '0)
                    || too_wide;
        uvar_err  = too_wide || ((value_reg != '0) && (value_w >= range_reg));

        // Signed mapping: negative v goes to 2|v|, positive v to 2v - 1.
        neg    = svalue_reg[VALUE_BITS-1];
        mag    = neg ? (~svalue_reg + VALUE_BITS'(1)) : svalue_reg;
        if (neg)
        begin
            mapped = {mag, 1'b0};
        end
        else if (mag != '0)
        begin
            mapped = {mag, 1'b0} - RANGE_BITS'(1);
        end
        else
        begin
            mapped = '0;
        end

        // The ue code word of v is v + 1 written in 2n + 1 bits.
        ue_x1  = ((kind_reg == KIND_SE) ? mapped : value_w) + RANGE_BITS'(1);
        ue_n1  = bit_len(ue_x1);
        ue_len = {ue_n1, 1'b0} - LEN_BITS'(1);

        uvar_len = (range_reg == '0) ? '0 :
                   LEN_BITS'(bit_len(range_reg - RANGE_BITS'(1)));

        out_enc = '{op: OP_ALIGN, err: 1'b0, code: '0, len: '0};
        case (kind_reg)
            KIND_FIXED:
            begin
                out_enc = '{op: OP_BITS, err: fixed_err,
                            code: CODE_BITS'(value_reg), len: LEN_BITS'(count_reg)};
            end
            KIND_UVAR:
            begin
                out_enc = '{op: OP_BITS, err: uvar_err,
                            code: CODE_BITS'(value_reg), len: uvar_len};
            end
            KIND_UE:
            begin
                out_enc = '{op: OP_BITS, err: too_wide, code: CODE_BITS'(ue_x1), len: ue_len};
            end
            KIND_SE:
            begin
                out_enc = '{op: OP_BITS, err: 1'b0, code: CODE_BITS'(ue_x1), len: ue_len};
            end
            KIND_ALIGN:
            begin
                out_enc = '{op: OP_ALIGN, err: 1'b0, code: '0, len: '0};
            end
            KIND_TRAIL:
            begin
                out_enc = '{op: OP_TRAIL, err: 1'b0, code: '0, len: '0};
            end
            default:
            begin
                out_enc = '{op: OP_ALIGN, err: 1'b0, code: '0, len: '0};
            end
        endcase
    end

endmodule

>>> src/egbw_pack.sv
// Packing stage of the Exp-Golomb bit writer: merges a code word with the pending bits.
// Holds the pending bit state and hands whole bytes to the drain; uses egbw_pkg.
module egbw_pack
    import egbw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  enc_t  in_enc,
    output logic  out_valid,
    input  logic  out_ready,
    output load_t out_load
);

    `include "exp_golomb_bit_writer_unit_assert.svh"

    logic                  v_reg;
    enc_t                  enc_reg;
    logic [2:0]            pcnt_reg;
    logic [6:0]            pbits_reg;

    logic [LEN_BITS-1:0]   len;
    logic [ACC_BITS-1:0]   code_w;
    logic [ACC_BITS-1:0]   acc;
    logic [LEN_BITS-1:0]   total;
    logic [NBYTE_BITS-1:0] nbytes;
    logic [2:0]            rem;
    logic [6:0]            new_mask;
    logic [6:0]            cur_mask;
    logic [6:0]            new_pbits;
    logic                  has_out;
    logic                  fire;

    always_comb
    begin
        len    = enc_reg.len;
        code_w = ACC_BITS'(enc_reg.code);
        case (enc_reg.op)
            OP_BITS:
            begin
                len    = enc_reg.len;
                code_w = ACC_BITS'(enc_reg.code);
            end
            OP_ALIGN:
            begin
                len    = LEN_BITS'(3'(3'd0 - pcnt_reg));
                code_w = '0;
            end
            OP_TRAIL:
            begin
                // A one bit followed by zeros always ends on the byte boundary.
                len    = LEN_BITS'(BYTE_BITS) - LEN_BITS'(pcnt_reg);
                code_w = ACC_BITS'(1) << (~pcnt_reg);
            end
            default:
            begin
                len    = '0;
                code_w = '0;
            end
        endcase

        acc       = (ACC_BITS'(pbits_reg) << len) | code_w;
        total     = LEN_BITS'(pcnt_reg) + len;
        nbytes    = total[LEN_BITS-1:3];
        rem       = total[2:0];
        new_mask  = 7'((8'd1 << rem) - 8'd1);
        cur_mask  = 7'((8'd1 << pcnt_reg) - 8'd1);
        new_pbits = acc[6:0] & new_mask;

        has_out   = enc_reg.err || (nbytes != '0);
        out_valid = v_reg && has_out;
        fire      = v_reg && (!has_out || out_ready);
        in_ready  = !v_reg || fire;

        out_load.err    = enc_reg.err;
        out_load.nbytes = enc_reg.err ? NBYTE_BITS'(1) : nbytes;
        out_load.data   = enc_reg.err ? '0 : (acc >> rem);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= 1'b0;
            pcnt_reg  <= '0;
            pbits_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                v_reg <= 1'b1;
            end
            else if (fire)
            begin
                v_reg <= 1'b0;
            end
            if (fire && !enc_reg.err)
            begin
                pcnt_reg  <= rem;
                pbits_reg <= new_pbits;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            enc_reg <= in_enc;
        end
    end

    `EGBW_ASSERT_NXT(a_err_keeps_state, clk, rst_n, fire && enc_reg.err, (pcnt_reg == $past(pcnt_reg)) && (pbits_reg == $past(pbits_reg)), "Rejected request changed the pending bits.")
    `EGBW_ASSERT_IMP(a_load_size, clk, rst_n, out_valid, (out_load.nbytes != '0) && (out_load.nbytes <= NBYTE_BITS'(MAX_BYTES)), "Byte count handed to the drain is out of range.")
    `EGBW_ASSERT_IMP(a_pending_clean, clk, rst_n, 1'b1, (pbits_reg & ~cur_mask) == '0, "Pending bits hold ones above the pending count.")

endmodule

>>> src/egbw_drain.sv
// Output register of the Exp-Golomb bit writer: sends the bytes of one request in order.
// Loaded from the packing stage; uses egbw_pkg.
module egbw_drain
    import egbw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  load_t                in_load,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_BITS-1:0] out_data,
    output logic                 out_last,
    output logic                 out_error
);

    `include "exp_golomb_bit_writer_unit_assert.svh"

    logic [NBYTE_BITS-1:0] cnt_reg;
    logic                  err_reg;
    logic [BYTE_BITS-1:0]  byte_reg [MAX_BYTES];
    logic [NBYTE_BITS-1:0] idx;

    always_comb
    begin
        in_ready  = (cnt_reg == '0) || ((cnt_reg == NBYTE_BITS'(1)) && out_ready);
        out_valid = cnt_reg != '0;
        out_last  = cnt_reg == NBYTE_BITS'(1);
        out_error = err_reg;
        idx       = cnt_reg - NBYTE_BITS'(1);
        out_data  = (idx < NBYTE_BITS'(MAX_BYTES)) ? byte_reg[idx] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (in_valid && in_ready)
        begin
            cnt_reg <= in_load.nbytes;
        end
        else if (out_valid && out_ready)
        begin
            cnt_reg <= cnt_reg - NBYTE_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            err_reg <= in_load.err;
            for (int i = 0; i < MAX_BYTES; i++)
            begin
                byte_reg[i] <= in_load.data[i*BYTE_BITS +: BYTE_BITS];
            end
        end
    end

    `EGBW_ASSERT_IMP(a_err_single, clk, rst_n, out_valid && out_error, out_last && (out_data == '0), "Error result is not a single zero byte.")
    `EGBW_ASSERT_NXT(a_count_down, clk, rst_n, out_valid && out_ready && (cnt_reg > NBYTE_BITS'(1)), cnt_reg == $past(cnt_reg) - NBYTE_BITS'(1), "Byte count did not step down after a taken byte.")

endmodule

>>> src/exp_golomb_bit_writer_unit.sv
// Top level of the Exp-Golomb bit writer.
// Instantiates egbw_encode, egbw_pack and egbw_drain; uses egbw_pkg.
//
// Each request on the s_axis channel writes one syntax element: fixed bits, a
// ranged unsigned field, a ue or se Exp-Golomb code, a byte alignment or RBSP
// trailing bits. The bits are packed MSB first and every completed byte leaves
// on the m_axis channel, first written bit in bit 7, with tlast on the final
// byte of the request. A request that fails its range check yields one zero
// byte with tuser and tlast set and leaves the pending bits untouched; a
// request that completes no byte yields nothing.
// Each request passes the encode and pack registers before its first byte is
// offered from the drain register.
// A new request can be accepted every cycle while each one yields at most one
// byte and tready stays high; a request yielding k bytes holds the byte-wide
// output register until they have all left, up to nine for the longest codes.
// Reset clears the pending bits and empties all stages. When the receiver
// stalls, the output byte holds and the stages behind it fill, after which
// s_axis_tready drops.
module exp_golomb_bit_writer_unit
    import egbw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // value, signed_value, bit_count, range, zero pad (lowest bit first)
    input  logic [IN_TDATA_BITS-1:0] s_axis_tdata,
    // kind
    input  logic [KIND_BITS-1:0]     s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // out_byte
    output logic [BYTE_BITS-1:0]     m_axis_tdata,
    output logic                     m_axis_tlast,
    // error
    output logic                     m_axis_tuser
);

    logic  enc_valid;
    logic  enc_ready;
    enc_t  enc;
    logic  load_valid;
    logic  load_ready;
    load_t load;

    egbw_encode u_encode (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .in_kind         (s_axis_tuser),
        .in_value        (s_axis_tdata[31:0]),
        .in_signed_value (s_axis_tdata[63:32]),
        .in_bit_count    (s_axis_tdata[69:64]),
        .in_range        (s_axis_tdata[102:70]),
        .out_valid       (enc_valid),
        .out_ready       (enc_ready),
        .out_enc         (enc)
    );

    egbw_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (enc_valid),
        .in_ready  (enc_ready),
        .in_enc    (enc),
        .out_valid (load_valid),
        .out_ready (load_ready),
        .out_load  (load)
    );

    egbw_drain u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (load_valid),
        .in_ready  (load_ready),
        .in_load   (load),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_error (m_axis_tuser)
    );

endmodule
